>>> design/terrain_slope_aspect_3x3_core_assert.svh
// assertion macros shared by the slope/aspect core
`ifndef TERRAIN_SLOPE_ASPECT_3X3_CORE_ASSERT_SVH
`define TERRAIN_SLOPE_ASPECT_3X3_CORE_ASSERT_SVH

// same-cycle implication
`define TSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsa assertion failed");

// implication after a fixed number of cycles
`define TSA_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("tsa latency assertion failed");

`endif

>>> design/tsa_pkg.sv
package tsa_pkg;

    localparam int GRAD_W   = 36;
    localparam int MAG_W    = 35;
    localparam int CORDIC_W = 34;
    localparam int ROOT_STEPS = 32;

    localparam logic [32:0] Q30_HALFPI    = 33'd1686629713;
    localparam logic [32:0] Q30_3HALFPI   = 33'd5059889139;
    localparam logic [29:0] K_DEG         = 30'd961263669;
    localparam logic [29:0] K_PCT         = 30'd1068070743;
    localparam logic [24:0] MAX_ANGLE_Q16 = 25'd23592960;
    localparam logic [24:0] MAX_PCT_Q16   = 25'd6553600;

    localparam logic [1:0] MODE_ASPECT  = 2'd0;
    localparam logic [1:0] MODE_SLOPE   = 2'd1;
    localparam logic [1:0] MODE_PERCENT = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [1:0] REG_OUTPUT_MODE = 2'd0;
    localparam logic [1:0] REG_ANGLE_UNITS = 2'd1;
    localparam logic [1:0] REG_CELL_SIZE   = 2'd2;
    localparam logic [1:0] REG_CONV_FACTOR = 2'd3;

    typedef enum logic [1:0] {
        FORCE_NONE,
        FORCE_ZERO,
        FORCE_HALF
    } t_force;

    typedef struct packed {
        logic signed [31:0] height_nw;
        logic signed [31:0] height_n;
        logic signed [31:0] height_ne;
        logic signed [31:0] height_w;
        logic signed [31:0] height_east;
        logic signed [31:0] height_sw;
        logic signed [31:0] height_s;
        logic signed [31:0] height_se;
        logic [7:0]         special_mask;
        logic               center_null;
    } t_in;

    typedef struct packed {
        logic [24:0] result_value;
        logic        result_valid;
    } t_out;

    // control that rides along with each item
    typedef struct packed {
        logic             vld;
        logic             inv;
        logic             aspect;
        logic             units;
        logic             pct;
        logic             west;
        logic             south;
        t_force           force_z;
        logic [2:0]       sh;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } t_side;

    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'h3243F6A8;
            1:  v = 30'h1DAC6705;
            2:  v = 30'h0FADBAFC;
            3:  v = 30'h07F56EA6;
            4:  v = 30'h03FEAB76;
            5:  v = 30'h01FFD55B;
            6:  v = 30'h00FFFAAA;
            7:  v = 30'h007FFF55;
            8:  v = 30'h003FFFEA;
            9:  v = 30'h001FFFFD;
            10: v = 30'h000FFFFF;
            11: v = 30'h0007FFFF;
            12: v = 30'h0003FFFF;
            13: v = 30'h0001FFFF;
            14: v = 30'h0000FFFF;
            15: v = 30'h00007FFF;
            16: v = 30'h00003FFF;
            17: v = 30'h00001FFF;
            18: v = 30'h00000FFF;
            19: v = 30'h000007FF;
            20: v = 30'h000003FF;
            21: v = 30'h000001FF;
            22: v = 30'h000000FF;
            23: v = 30'h0000007F;
            24: v = 30'h0000003F;
            25: v = 30'h0000001F;
            26: v = 30'h0000000F;
            27: v = 30'h00000008;
            28: v = 30'h00000004;
            29: v = 30'h00000002;
            30: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // priority encoder: index of top set bit plus one
    function automatic logic [6:0] bit_len64(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> design/tsa_grad.sv
module tsa_grad #(
    parameter int HEIGHT_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  tsa_pkg::t_in    i_item,
    input  logic [1:0]      i_mode,
    input  logic            i_units,
    input  logic [31:0]     i_cell_size,
    input  logic [31:0]     i_conv_factor,
    output tsa_pkg::t_side  o_side,
    output logic [62:0]     o_sum
);
    import tsa_pkg::*;

    localparam int HW_EFF = (HEIGHT_WIDTH < 32) ? HEIGHT_WIDTH : 32;

    function automatic logic signed [GRAD_W-1:0] sext(input logic [31:0] h);
        return GRAD_W'(signed'(h[HW_EFF-1:0]));
    endfunction

    logic signed [GRAD_W-1:0] nx, ny;
    logic [1:0]               mode_eff;
    logic                     r1_vld, r1_inv, r1_aspect, r1_units, r1_pct;
    logic signed [GRAD_W-1:0] r1_nx, r1_ny;

    always_comb begin
        nx = (sext(i_item.height_ne) + (sext(i_item.height_east) <<< 1) + sext(i_item.height_se))
           - (sext(i_item.height_nw) + (sext(i_item.height_w) <<< 1) + sext(i_item.height_sw));
        ny = (sext(i_item.height_sw) + (sext(i_item.height_s) <<< 1) + sext(i_item.height_se))
           - (sext(i_item.height_nw) + (sext(i_item.height_n) <<< 1) + sext(i_item.height_ne));
        mode_eff = (i_mode == MODE_UNUSED) ? MODE_SLOPE : i_mode;
    end

    always_ff @(posedge i_clk) begin
        r1_nx     <= nx;
        r1_ny     <= ny;
        r1_inv    <= (i_item.special_mask != 8'd0)
                  || ((mode_eff != MODE_ASPECT) && i_item.center_null);
        r1_aspect <= (mode_eff == MODE_ASPECT);
        r1_units  <= i_units;
        r1_pct    <= (mode_eff == MODE_PERCENT);
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
    end

    // magnitude, prescale below 2^31, special cases
    logic [MAG_W-1:0] ax, ay, orv;
    logic [6:0]       orl;
    logic [2:0]       sh;
    t_side            side2;
    t_side            r2_side, r3_side, r4_side;
    logic [30:0]      r2_xs, r2_ys;
    logic [61:0]      r3_sqx, r3_sqy;
    logic [62:0]      r4_sum;

    always_comb begin
        ax  = MAG_W'(r1_nx[GRAD_W-1] ? -r1_nx : r1_nx);
        ay  = MAG_W'(r1_ny[GRAD_W-1] ? -r1_ny : r1_ny);
        orv = ax | ay;
        orl = bit_len64(64'(orv));
        sh  = (orl > 7'd31) ? 3'(orl - 7'd31) : 3'd0;
        side2.vld    = r1_vld;
        side2.inv    = r1_inv;
        side2.aspect = r1_aspect;
        side2.units  = r1_units;
        side2.pct    = r1_pct;
        side2.west   = ~r1_nx[GRAD_W-1];
        side2.south  = r1_ny[GRAD_W-1];
        side2.sh     = sh;
        side2.ax     = ax;
        side2.ay     = ay;
        if (orv == '0) begin
            side2.force_z = FORCE_ZERO;
        end else if (!r1_aspect && (i_conv_factor == 32'd0)) begin
            side2.force_z = FORCE_ZERO;
        end else if (!r1_aspect && (i_cell_size == 32'd0)) begin
            side2.force_z = FORCE_HALF;
        end else begin
            side2.force_z = FORCE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_xs   <= 31'(ax >> sh);
        r2_ys   <= 31'(ay >> sh);
        r3_sqx  <= 62'(r2_xs) * 62'(r2_xs);
        r3_sqy  <= 62'(r2_ys) * 62'(r2_ys);
        r4_sum  <= 63'(r3_sqx) + 63'(r3_sqy);
        if (!i_rst_n) begin
            r2_side.vld <= 1'b0;
            r3_side.vld <= 1'b0;
            r4_side.vld <= 1'b0;
        end else begin
            r2_side <= side2;
            r3_side <= r2_side;
            r4_side <= r3_side;
        end
    end

    assign o_side = r4_side;
    assign o_sum  = r4_sum;
endmodule

>>> design/tsa_isqrt.sv
module tsa_isqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsa_pkg::t_side  i_side,
    input  logic [62:0]     i_n,
    output tsa_pkg::t_side  o_side,
    output logic [31:0]     o_root
);
    import tsa_pkg::*;

    logic [63:0] r_n    [0:ROOT_STEPS-1];
    logic [63:0] r_r    [0:ROOT_STEPS-1];
    t_side       r_side [0:ROOT_STEPS-1];

    // one result bit per stage, restoring
    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
        logic [63:0] n_in, r_in, bitv, trial;
        t_side       s_in;
        if (j == 0) begin : g_first
            assign n_in = {1'b0, i_n};
            assign r_in = '0;
            assign s_in = i_side;
        end else begin : g_next
            assign n_in = r_n[j-1];
            assign r_in = r_r[j-1];
            assign s_in = r_side[j-1];
        end
        assign bitv  = 64'd1 << (62 - 2 * j);
        assign trial = r_in + bitv;

        always_ff @(posedge i_clk) begin
            if (n_in >= trial) begin
                r_n[j] <= n_in - trial;
                r_r[j] <= (r_in >> 1) + bitv;
            end else begin
                r_n[j] <= n_in;
                r_r[j] <= r_in >> 1;
            end
            if (!i_rst_n) begin
                r_side[j].vld <= 1'b0;
            end else begin
                r_side[j] <= s_in;
            end
        end
    end

    assign o_side = r_side[ROOT_STEPS-1];
    assign o_root = r_r[ROOT_STEPS-1][31:0];
endmodule

>>> design/tsa_align.sv
module tsa_align (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsa_pkg::t_side  i_side,
    input  logic [31:0]     i_root,
    input  logic [31:0]     i_cell_size,
    input  logic [31:0]     i_conv_factor,
    output tsa_pkg::t_side  o_side,
    output logic [30:0]     o_x,
    output logic [30:0]     o_y
);
    import tsa_pkg::*;

    function automatic logic [30:0] place(input logic [63:0] v, input logic signed [7:0] e);
        logic [6:0]  mag;
        logic [63:0] t;
        mag = 7'(-e);
        if (e >= 0) begin
            t = v << e[6:0];
        end else if (mag >= 7'd64) begin
            t = '0;
        end else begin
            t = v >> mag;
        end
        return t[30:0];
    endfunction

    logic [63:0] prod;
    t_side       rp_side, rl_side, rk_side, rh_side;
    logic [63:0] rp_a, rl_a, rk_a;
    logic [MAG_W-1:0] rp_b, rl_b, rk_b;
    logic [2:0]  rp_ea, rl_ea;
    logic [3:0]  rp_eb, rl_eb;
    logic [6:0]  rl_la, rl_lb;
    logic [6:0]  lmax;
    logic signed [7:0] kk;
    logic signed [7:0] rk_sa, rk_sb;
    logic [30:0] rh_x, rh_y;

    assign prod = i_root * i_conv_factor;
    assign lmax = (rl_la > rl_lb) ? rl_la : rl_lb;
    assign kk   = signed'({1'b0, lmax}) - 8'sd30;

    always_ff @(posedge i_clk) begin
        // operand select: aspect uses the gradients, slope uses |N|*cf over cell size
        if (i_side.aspect) begin
            rp_a  <= 64'(i_side.ay);
            rp_b  <= i_side.ax;
            rp_ea <= 3'd0;
            rp_eb <= 4'd0;
        end else begin
            rp_a  <= prod;
            rp_b  <= MAG_W'(i_cell_size);
            rp_ea <= i_side.sh;
            rp_eb <= 4'd11;
        end

        rl_a    <= rp_a;
        rl_b    <= rp_b;
        rl_ea   <= rp_ea;
        rl_eb   <= rp_eb;
        rl_la   <= bit_len64(rp_a) + 7'(rp_ea);
        rl_lb   <= bit_len64(64'(rp_b)) + 7'(rp_eb);

        rk_a    <= rl_a;
        rk_b    <= rl_b;
        rk_sa   <= signed'({5'd0, rl_ea}) - kk;
        rk_sb   <= signed'({4'd0, rl_eb}) - kk;

        rh_y    <= place(rk_a, rk_sa);
        rh_x    <= place(64'(rk_b), rk_sb);

        if (!i_rst_n) begin
            rp_side.vld <= 1'b0;
            rl_side.vld <= 1'b0;
            rk_side.vld <= 1'b0;
            rh_side.vld <= 1'b0;
        end else begin
            rp_side <= i_side;
            rl_side <= rp_side;
            rk_side <= rl_side;
            rh_side <= rk_side;
        end
    end

    assign o_side = rh_side;
    assign o_x    = rh_x;
    assign o_y    = rh_y;
endmodule

>>> design/tsa_cordic.sv
module tsa_cordic #(
    parameter int STAGES = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsa_pkg::t_side                i_side,
    input  logic [30:0]                   i_x,
    input  logic [30:0]                   i_y,
    output tsa_pkg::t_side                o_side,
    output logic signed [tsa_pkg::CORDIC_W-1:0] o_z
);
    import tsa_pkg::*;

    logic signed [CORDIC_W-1:0] r_x    [0:STAGES-1];
    logic signed [CORDIC_W-1:0] r_y    [0:STAGES-1];
    logic signed [CORDIC_W-1:0] r_z    [0:STAGES-1];
    t_side                      r_side [0:STAGES-1];

    // vectoring: drive y toward zero, collect the angle in z
    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [CORDIC_W-1:0] x_in, y_in, z_in, ang;
        t_side                      s_in;
        if (i == 0) begin : g_first
            assign x_in = CORDIC_W'(i_x);
            assign y_in = CORDIC_W'(i_y);
            assign z_in = '0;
            assign s_in = i_side;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
            assign s_in = r_side[i-1];
        end
        assign ang = CORDIC_W'(atan_q30(i));

        always_ff @(posedge i_clk) begin
            if (!y_in[CORDIC_W-1]) begin
                r_x[i] <= x_in + (y_in >>> i);
                r_y[i] <= y_in - (x_in >>> i);
                r_z[i] <= z_in + ang;
            end else begin
                r_x[i] <= x_in - (y_in >>> i);
                r_y[i] <= y_in + (x_in >>> i);
                r_z[i] <= z_in - ang;
            end
            if (!i_rst_n) begin
                r_side[i].vld <= 1'b0;
            end else begin
                r_side[i] <= s_in;
            end
        end
    end

    assign o_side = r_side[STAGES-1];
    assign o_z    = r_z[STAGES-1];
endmodule

>>> design/terrain_slope_aspect_3x3_core.sv
// channel   | ports                                  | transfer when
// ----------+----------------------------------------+-----------------------------
// item in   | start, busy, i_item                    | start high, busy low
// result    | o_done, o_result                       | o_done high, one cycle
// config    | psel penable pwrite paddr pwdata ...   | psel, penable, pwrite, pready
//
// one item per cycle; each item passes through the gradient stages, the 32-step square
// root pipeline, the align stages, the cordic rotation stages and the output stages
// reset clears all stage valid bits and loads the register defaults
// busy is always low and nothing stalls: every stage moves every cycle
`include "terrain_slope_aspect_3x3_core_assert.svh"

module terrain_slope_aspect_3x3_core #(
    parameter int HEIGHT_WIDTH  = 32,
    parameter int CORDIC_STAGES = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tsa_pkg::t_in   i_item,
    output logic           o_done,
    output tsa_pkg::t_out  o_result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import tsa_pkg::*;

    localparam int LATENCY = 4 + ROOT_STEPS + 4 + CORDIC_STAGES + 3;

    logic [1:0]  r_output_mode;
    logic        r_angle_units;
    logic [31:0] r_cell_size;
    logic [31:0] r_conv_factor;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_mode <= MODE_SLOPE;
            r_angle_units <= 1'b0;
            r_cell_size   <= 32'd65536;
            r_conv_factor <= 32'd65536;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_OUTPUT_MODE: r_output_mode <= pwdata[1:0];
                REG_ANGLE_UNITS: r_angle_units <= pwdata[0];
                REG_CELL_SIZE:   r_cell_size   <= pwdata;
                REG_CONV_FACTOR: r_conv_factor <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OUTPUT_MODE: prdata = {30'd0, r_output_mode};
            REG_ANGLE_UNITS: prdata = {31'd0, r_angle_units};
            REG_CELL_SIZE:   prdata = r_cell_size;
            REG_CONV_FACTOR: prdata = r_conv_factor;
            default:         prdata = '0;
        endcase
    end

    t_side       grad_side, root_side, align_side, cordic_side;
    logic [62:0] grad_sum;
    logic [31:0] root;
    logic [30:0] al_x, al_y;
    logic signed [CORDIC_W-1:0] cz;

    tsa_grad #(
        .HEIGHT_WIDTH(HEIGHT_WIDTH)
    ) u_grad (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (start && !busy),
        .i_item        (i_item),
        .i_mode        (r_output_mode),
        .i_units       (r_angle_units),
        .i_cell_size   (r_cell_size),
        .i_conv_factor (r_conv_factor),
        .o_side        (grad_side),
        .o_sum         (grad_sum)
    );

    tsa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (grad_side),
        .i_n     (grad_sum),
        .o_side  (root_side),
        .o_root  (root)
    );

    tsa_align u_align (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_side        (root_side),
        .i_root        (root),
        .i_cell_size   (r_cell_size),
        .i_conv_factor (r_conv_factor),
        .o_side        (align_side),
        .o_x           (al_x),
        .o_y           (al_y)
    );

    tsa_cordic #(
        .STAGES(CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (align_side),
        .i_x     (al_x),
        .i_y     (al_y),
        .o_side  (cordic_side),
        .o_z     (cz)
    );

    // clamp, special angles, quadrant fold
    logic [32:0] t_ang, z_full;
    t_side       r_f1_side, r_f2_side;
    logic [32:0] r_f1_z;
    logic [63:0] r_f2_prod;
    logic        rad;
    logic [63:0] v;
    logic [24:0] v_clamp;
    logic        r_done;
    t_out        r_result;

    always_comb begin
        if (cz[CORDIC_W-1]) begin
            t_ang = '0;
        end else if (cz > signed'({1'b0, Q30_HALFPI})) begin
            t_ang = Q30_HALFPI;
        end else begin
            t_ang = 33'(cz);
        end
        case (cordic_side.force_z)
            FORCE_ZERO: t_ang = '0;
            FORCE_HALF: t_ang = Q30_HALFPI;
            default: ;
        endcase
        if (!cordic_side.aspect) begin
            z_full = t_ang;
        end else if (!cordic_side.west && !cordic_side.south) begin
            z_full = Q30_HALFPI - t_ang;
        end else if (cordic_side.west && !cordic_side.south) begin
            z_full = Q30_3HALFPI + t_ang;
        end else if (cordic_side.west && cordic_side.south) begin
            z_full = Q30_3HALFPI - t_ang;
        end else begin
            z_full = Q30_HALFPI + t_ang;
        end
    end

    assign rad = r_f1_side.units && !r_f1_side.pct;

    always_comb begin
        if (r_f2_side.units && !r_f2_side.pct) begin
            v = r_f2_prod >> 14;
        end else begin
            v = (r_f2_prod + (64'd1 << 37)) >> 38;
        end
        if (r_f2_side.pct && (v > 64'(MAX_PCT_Q16))) begin
            v_clamp = MAX_PCT_Q16;
        end else if (v > 64'(MAX_ANGLE_Q16)) begin
            v_clamp = MAX_ANGLE_Q16;
        end else begin
            v_clamp = v[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_z    <= z_full;
        if (rad) begin
            r_f2_prod <= 64'(r_f1_z) + 64'd8192;
        end else begin
            r_f2_prod <= 64'(r_f1_z) * 64'(r_f1_side.pct ? K_PCT : K_DEG);
        end
        r_result.result_value <= r_f2_side.inv ? 25'd0 : v_clamp;
        r_result.result_valid <= !r_f2_side.inv;
        if (!i_rst_n) begin
            r_f1_side.vld <= 1'b0;
            r_f2_side.vld <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_f1_side <= cordic_side;
            r_f2_side <= r_f1_side;
            r_done    <= r_f2_side.vld;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    logic null_res;
    assign null_res = o_done && !o_result.result_valid;

    `TSA_ASSERT_DELAY(a_latency, i_clk, i_rst_n, start && !busy, LATENCY, o_done)
    `TSA_ASSERT_IMPLY(a_done_source, i_clk, i_rst_n, o_done, $past(start, LATENCY))
    `TSA_ASSERT_IMPLY(a_null_zero, i_clk, i_rst_n, null_res, o_result.result_value == 25'd0)
    `TSA_ASSERT_IMPLY(a_range, i_clk, i_rst_n, o_done, o_result.result_value <= MAX_ANGLE_Q16)
endmodule
